[design/fbp_pkg.sv]
// ============================================================================
// Fill-first bucket packer package
// Shared widths, register indexes, reset values and bundle types.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package fbp_pkg;

    localparam int SIZE_W     = 16;
    localparam int COUNT_W    = 13;
    localparam int SEQCAP_W   = 20;
    localparam int CMPCAP_W   = 16;
    localparam int BATCH_W    = 16;
    localparam int BUCKET_W   = 12;
    localparam int OFFSET_W   = 20;
    localparam int LONGEST_W  = 16;
    localparam int PAIRS_W    = 16;
    localparam int LEN_W      = SEQCAP_W + 1;
    localparam int ADDR_W     = 4;
    localparam int PDATA_W    = 32;
    localparam int IN_DATA_W  = 2 * SIZE_W;
    localparam int OUT_DATA_W = 88;

    localparam int SEEDS_PER_PAIR_DEF = 2;

    localparam logic [COUNT_W-1:0]  BUCKET_COUNT_RST = 13'd1024;
    localparam logic [SEQCAP_W-1:0] SEQ_CAP_RST      = 20'd65536;
    localparam logic [CMPCAP_W-1:0] CMP_CAP_RST      = 16'd1024;
    localparam logic [COUNT_W-1:0]  BUCKET_MAX       = 13'd4096;

    typedef enum logic [1:0] {
        REG_BUCKET_COUNT = 2'd0,
        REG_SEQ_CAP      = 2'd1,
        REG_CMP_CAP      = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  bucket_count;
        logic [SEQCAP_W-1:0] sequence_capacity;
        logic [CMPCAP_W-1:0] comparison_capacity;
    } cfg_t;

    typedef struct packed {
        logic                 status;
        logic [BATCH_W-1:0]   batch_index;
        logic [BUCKET_W-1:0]  bucket_index;
        logic [OFFSET_W-1:0]  offset_a;
        logic [OFFSET_W-1:0]  offset_b;
        logic [LONGEST_W-1:0] longest_length;
    } result_t;

endpackage

`default_nettype wire

[design/fbp_cfg.sv]
// ============================================================================
// Fill-first bucket packer configuration registers
// APB-style register file for bucket count and the two capacities.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fbp_cfg
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fbp_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [fbp_pkg::PDATA_W-1:0]   pwdata,
    output logic      [fbp_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    output fbp_pkg::cfg_t                      cfg
);

    fbp_pkg::cfg_t     cfg_reg;
    fbp_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign idx    = fbp_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bucket_count        <= fbp_pkg::BUCKET_COUNT_RST;
            cfg_reg.sequence_capacity   <= fbp_pkg::SEQ_CAP_RST;
            cfg_reg.comparison_capacity <= fbp_pkg::CMP_CAP_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                fbp_pkg::REG_BUCKET_COUNT:
                    cfg_reg.bucket_count <= pwdata[fbp_pkg::COUNT_W-1:0];
                fbp_pkg::REG_SEQ_CAP:
                    cfg_reg.sequence_capacity <= pwdata[fbp_pkg::SEQCAP_W-1:0];
                fbp_pkg::REG_CMP_CAP:
                    cfg_reg.comparison_capacity <= pwdata[fbp_pkg::CMPCAP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            fbp_pkg::REG_BUCKET_COUNT:
                prdata = fbp_pkg::PDATA_W'(cfg_reg.bucket_count);
            fbp_pkg::REG_SEQ_CAP:
                prdata = fbp_pkg::PDATA_W'(cfg_reg.sequence_capacity);
            fbp_pkg::REG_CMP_CAP:
                prdata = fbp_pkg::PDATA_W'(cfg_reg.comparison_capacity);
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[design/fbp_placer.sv]
// ============================================================================
// Fill-first bucket packer placement core
// Holds the open bucket and decides, in one pass, where a pair lands.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fbp_placer
#(
    parameter int SEEDS_PER_PAIR = fbp_pkg::SEEDS_PER_PAIR_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         step,
    input  wire logic [fbp_pkg::SIZE_W-1:0]   size_a,
    input  wire logic [fbp_pkg::SIZE_W-1:0]   size_b,
    input  fbp_pkg::cfg_t                     cfg,
    output fbp_pkg::result_t                  result
);

    localparam int CMP_W = fbp_pkg::PAIRS_W + 1 + $clog2(SEEDS_PER_PAIR + 1);

    logic [fbp_pkg::BUCKET_W-1:0]  bucket_reg,  bucket_next;
    logic [fbp_pkg::BATCH_W-1:0]   batch_reg,   batch_next;
    logic [fbp_pkg::SEQCAP_W-1:0]  used_reg,    used_next;
    logic [fbp_pkg::PAIRS_W-1:0]   pairs_reg,   pairs_next;
    logic [fbp_pkg::LONGEST_W-1:0] longest_reg, longest_next;

    logic [fbp_pkg::COUNT_W-1:0]   count_eff;
    logic [fbp_pkg::LEN_W-1:0]     pair_len;
    logic [fbp_pkg::LEN_W-1:0]     len_cur;
    logic [CMP_W-1:0]              cmp_cur;
    logic [CMP_W-1:0]              cmp_cap;
    logic                          fit_cur;
    logic                          fit_empty;
    logic                          too_large;
    logic                          last_bucket;
    logic [fbp_pkg::BUCKET_W-1:0]  bucket_base;
    logic [fbp_pkg::BATCH_W-1:0]   batch_base;
    logic [fbp_pkg::SEQCAP_W-1:0]  used_base;
    logic [fbp_pkg::PAIRS_W-1:0]   pairs_base;
    logic [fbp_pkg::LONGEST_W-1:0] longest_base;
    logic [fbp_pkg::LONGEST_W-1:0] longest_ab;

    always_comb
    begin
        if (cfg.bucket_count == '0)
            count_eff = fbp_pkg::COUNT_W'(1);
        else if (cfg.bucket_count > fbp_pkg::BUCKET_MAX)
            count_eff = fbp_pkg::BUCKET_MAX;
        else
            count_eff = cfg.bucket_count;
    end

    assign pair_len  = fbp_pkg::LEN_W'(size_a) + fbp_pkg::LEN_W'(size_b);
    assign len_cur   = fbp_pkg::LEN_W'(used_reg) + pair_len;
    assign cmp_cap   = CMP_W'(cfg.comparison_capacity);
    assign cmp_cur   = CMP_W'((CMP_W'(pairs_reg) + CMP_W'(1)) * CMP_W'(SEEDS_PER_PAIR));
    assign fit_cur   = (len_cur <= fbp_pkg::LEN_W'(cfg.sequence_capacity)) &&
                       (cmp_cur <= cmp_cap);
    assign fit_empty = (pair_len <= fbp_pkg::LEN_W'(cfg.sequence_capacity)) &&
                       (CMP_W'(SEEDS_PER_PAIR) <= cmp_cap);
    assign too_large = !fit_cur && !fit_empty;

    // A lowered bucket count can leave the open bucket beyond the end; the
    // compare against the count then rolls over to a new batch as well.
    assign last_bucket = (fbp_pkg::COUNT_W'(bucket_reg) + fbp_pkg::COUNT_W'(1)) >= count_eff;

    always_comb
    begin
        if (fit_cur)
        begin
            bucket_base  = bucket_reg;
            batch_base   = batch_reg;
            used_base    = used_reg;
            pairs_base   = pairs_reg;
            longest_base = longest_reg;
        end
        else
        begin
            bucket_base  = last_bucket ? '0 : bucket_reg + fbp_pkg::BUCKET_W'(1);
            batch_base   = last_bucket ? batch_reg + fbp_pkg::BATCH_W'(1) : batch_reg;
            used_base    = '0;
            pairs_base   = '0;
            longest_base = '0;
        end
    end

    assign longest_ab = (size_a > size_b) ? size_a : size_b;

    always_comb
    begin
        bucket_next  = bucket_base;
        batch_next   = batch_base;
        used_next    = used_base + fbp_pkg::SEQCAP_W'(pair_len);
        pairs_next   = pairs_base + fbp_pkg::PAIRS_W'(1);
        longest_next = (longest_ab > longest_base) ? longest_ab : longest_base;
    end

    always_comb
    begin
        if (too_large)
        begin
            result        = '0;
            result.status = 1'b1;
        end
        else
        begin
            result.status         = 1'b0;
            result.batch_index    = batch_base;
            result.bucket_index   = bucket_base;
            result.offset_a       = used_base;
            result.offset_b       = used_base + fbp_pkg::OFFSET_W'(size_a);
            result.longest_length = longest_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_reg  <= '0;
            batch_reg   <= '0;
            used_reg    <= '0;
            pairs_reg   <= '0;
            longest_reg <= '0;
        end
        else if (step && !too_large)
        begin
            bucket_reg  <= bucket_next;
            batch_reg   <= batch_next;
            used_reg    <= used_next;
            pairs_reg   <= pairs_next;
            longest_reg <= longest_next;
        end
    end

endmodule

`default_nettype wire

[design/fill_first_bucket_packer.sv]
// ============================================================================
// Fill-first bucket packer
// Next-fit placement of sequence pairs into buckets and batches.
// ============================================================================
// Usage: each transaction on the s_ channel carries one pair of sequence
// lengths; each transaction on the m_ channel returns where that pair went:
// batch, bucket, the two buffer offsets and the bucket's longest length, or
// a too-large flag in m_tuser with all data zero. One result per pair, in order.
// A pair sits in an input register while the placement logic works on it,
// and its result is then loaded into an output register, from which it is
// shown. One pair per cycle is sustained while the receiver takes results,
// since the open-bucket registers update in the same cycle.
// When the receiver stalls, the output register holds its result and the
// input register holds the next pair; s_tready falls only when both are full.
// Reset empties both registers, closes all buckets (batch 0, bucket 0) and
// loads the registers with bucket_count 1024, sequence_capacity 65536 and
// comparison_capacity 1024. Register writes leave the packing state alone.
// The user must make them while no transaction is in flight; no logic checks it.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fill_first_bucket_packer
#(
    parameter int SEEDS_PER_PAIR = fbp_pkg::SEEDS_PER_PAIR_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // s_tdata: size_a [15:0], size_b [31:16]
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [fbp_pkg::IN_DATA_W-1:0]   s_tdata,
    // m_tdata: batch_index [15:0], bucket_index [27:16], offset_a [47:28],
    // offset_b [67:48], longest_length [83:68], zero [87:84]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [fbp_pkg::OUT_DATA_W-1:0]       m_tdata,
    // m_tuser: status [0]
    output logic [0:0]                           m_tuser,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fbp_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [fbp_pkg::PDATA_W-1:0]     pwdata,
    output logic [fbp_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready
);

    fbp_pkg::cfg_t    cfg;
    fbp_pkg::result_t result;
    fbp_pkg::result_t out_res_reg;

    logic                         in_valid_reg;
    logic [fbp_pkg::SIZE_W-1:0]   in_a_reg;
    logic [fbp_pkg::SIZE_W-1:0]   in_b_reg;
    logic                         out_valid_reg;
    logic                         step;

    fbp_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fbp_placer
    #(
        .SEEDS_PER_PAIR (SEEDS_PER_PAIR)
    )
    u_placer
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .size_a (in_a_reg),
        .size_b (in_b_reg),
        .cfg    (cfg),
        .result (result)
    );

    // The held pair moves on whenever the output register is free or drains.
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (step)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_a_reg <= s_tdata[fbp_pkg::SIZE_W-1:0];
            in_b_reg <= s_tdata[fbp_pkg::IN_DATA_W-1:fbp_pkg::SIZE_W];
        end
        if (step)
            out_res_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = fbp_pkg::OUT_DATA_W'({out_res_reg.longest_length,
                                             out_res_reg.offset_b,
                                             out_res_reg.offset_a,
                                             out_res_reg.bucket_index,
                                             out_res_reg.batch_index});

endmodule

`default_nettype wire

[design/fbp_checker.sv]
// ============================================================================
// Fill-first bucket packer port checker
// Watches the stream ports of the top level for consistent results.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fbp_checker
(
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_tready,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [fbp_pkg::OUT_DATA_W-1:0]     m_tdata,
    input wire logic [0:0]                         m_tuser
);

    // With the output register empty the input side can always take a pair.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("s_tready low while no result is pending");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("rejected pair carries nonzero fields");

    // The second sequence is stored right after the first one.
    a_offset_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[67:48] >= m_tdata[47:28])
        else $error("offset_b below offset_a");

endmodule

bind fill_first_bucket_packer fbp_checker u_fbp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[tb/sv/fill_first_bucket_packer_tb.sv]
// ============================================================================
// Fill-first bucket packer testbench
// Drives pairs of sequence lengths into the packer over the stream input,
// predicts each placement with a next-fit model kept in step with the APB
// register writes, and compares every returned placement field by field.
// Covers field extremes, pair and length limits, oversized pairs, bucket
// count edge values, lowered capacities, bucket wrap into a new batch, a
// long receiver stall and several random register settings.
// ============================================================================
`timescale 1ns / 1ps

module fill_first_bucket_packer_tb;

    localparam int SEEDS        = fbp_pkg::SEEDS_PER_PAIR_DEF;
    localparam int STALL_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 60;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    wire                            s_tready;
    // s_tdata: size_a [15:0], size_b [31:16]
    logic [fbp_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    wire                            m_tvalid;
    logic                           m_tready = 1'b0;
    // m_tdata: batch_index [15:0], bucket_index [27:16], offset_a [47:28],
    // offset_b [67:48], longest_length [83:68], zero [87:84]
    wire [fbp_pkg::OUT_DATA_W-1:0]  m_tdata;
    // m_tuser: status [0]
    wire [0:0]                      m_tuser;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [fbp_pkg::ADDR_W-1:0]     paddr = '0;
    logic [fbp_pkg::PDATA_W-1:0]    pwdata = '0;
    wire [fbp_pkg::PDATA_W-1:0]     prdata;
    wire                            pready;

    fill_first_bucket_packer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Register copies and open-bucket state of the predictor.
    logic [fbp_pkg::COUNT_W-1:0]   cfg_buckets = fbp_pkg::BUCKET_COUNT_RST;
    logic [fbp_pkg::SEQCAP_W-1:0]  cfg_seq_cap = fbp_pkg::SEQ_CAP_RST;
    logic [fbp_pkg::CMPCAP_W-1:0]  cfg_cmp_cap = fbp_pkg::CMP_CAP_RST;
    logic [fbp_pkg::BUCKET_W-1:0]  st_bucket = '0;
    logic [fbp_pkg::BATCH_W-1:0]   st_batch = '0;
    logic [fbp_pkg::OFFSET_W-1:0]  st_used = '0;
    logic [fbp_pkg::PAIRS_W-1:0]   st_pairs = '0;
    logic [fbp_pkg::LONGEST_W-1:0] st_longest = '0;

    fbp_pkg::result_t placement_q[$];
    int      mismatches = 0;
    bit      tx_idle_en = 1'b1;
    bit      rx_idle_en = 1'b1;
    int      hold_reqs = 0;
    int      hold_seen = 0;
    int      hold_left = 0;
    int      stall_cycles = 0;

    function automatic bit pair_fits(input logic [fbp_pkg::OFFSET_W-1:0] used,
                                     input logic [fbp_pkg::PAIRS_W-1:0] pairs,
                                     input logic [fbp_pkg::SIZE_W-1:0] a,
                                     input logic [fbp_pkg::SIZE_W-1:0] b);
        longint unsigned need_len;
        longint unsigned need_cmp;
        need_len = used;
        need_len = need_len + a + b;
        need_cmp = pairs;
        need_cmp = (need_cmp + 1) * SEEDS;
        return need_len <= cfg_seq_cap && need_cmp <= cfg_cmp_cap;
    endfunction

    function automatic fbp_pkg::result_t place_pair(input logic [fbp_pkg::SIZE_W-1:0] a,
                                                    input logic [fbp_pkg::SIZE_W-1:0] b);
        fbp_pkg::result_t r;
        int unsigned      span;
        r = '0;
        span = cfg_buckets;
        if (span == 0)
            span = 1;
        if (span > int'(fbp_pkg::BUCKET_MAX))
            span = int'(fbp_pkg::BUCKET_MAX);
        if (!pair_fits(st_used, st_pairs, a, b))
        begin
            // An oversized pair leaves the open bucket untouched.
            if (!pair_fits('0, '0, a, b))
            begin
                r.status = 1'b1;
                return r;
            end
            if (int'(st_bucket) + 1 >= span)
            begin
                st_bucket = '0;
                st_batch  = st_batch + 1'b1;
            end
            else
                st_bucket = st_bucket + 1'b1;
            st_used    = '0;
            st_pairs   = '0;
            st_longest = '0;
        end
        r.batch_index  = st_batch;
        r.bucket_index = st_bucket;
        r.offset_a     = st_used;
        r.offset_b     = st_used + a;
        st_used  = st_used + a + b;
        st_pairs = st_pairs + 1'b1;
        if (a > st_longest)
            st_longest = a;
        if (b > st_longest)
            st_longest = b;
        r.longest_length = st_longest;
        return r;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endfunction

    task automatic check_placement();
        fbp_pkg::result_t want;
        if (placement_q.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected placement, expected none, actual %h %h",
                     $time, m_tuser, m_tdata);
        end
        else
        begin
            want = placement_q.pop_front();
            check_field("status", want.status, m_tuser[0]);
            check_field("batch_index", want.batch_index, m_tdata[15:0]);
            check_field("bucket_index", want.bucket_index, m_tdata[27:16]);
            check_field("offset_a", want.offset_a, m_tdata[47:28]);
            check_field("offset_b", want.offset_b, m_tdata[67:48]);
            check_field("longest_length", want.longest_length, m_tdata[83:68]);
            check_field("tdata padding", 0, m_tdata[87:84]);
        end
    endtask

    // Result side: checks each transaction, then decides the next tready.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_placement();
            if (hold_reqs != hold_seen)
            begin
                hold_seen <= hold_reqs;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= !(rx_idle_en && $urandom_range(0, 99) < 12);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("fill_first_bucket_packer_tb: done, errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_pair(input logic [fbp_pkg::SIZE_W-1:0] a,
                             input logic [fbp_pkg::SIZE_W-1:0] b);
        if (tx_idle_en && $urandom_range(0, 99) < 6)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        do @(posedge clk); while (!s_tready);
        placement_q.insert(placement_q.size(), place_pair(a, b));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (placement_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input fbp_pkg::reg_idx_t idx,
                             input logic [fbp_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input fbp_pkg::reg_idx_t idx,
                            output logic [fbp_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_reg(input fbp_pkg::reg_idx_t idx,
                           input logic [fbp_pkg::PDATA_W-1:0] value);
        logic [fbp_pkg::PDATA_W-1:0] mask;
        logic [fbp_pkg::PDATA_W-1:0] readback;
        case (idx)
            fbp_pkg::REG_BUCKET_COUNT: mask = 32'h1FFF;
            fbp_pkg::REG_SEQ_CAP:      mask = 32'hF_FFFF;
            default:                   mask = 32'hFFFF;
        endcase
        apb_write(idx, value);
        case (idx)
            fbp_pkg::REG_BUCKET_COUNT: cfg_buckets = value[fbp_pkg::COUNT_W-1:0];
            fbp_pkg::REG_SEQ_CAP:      cfg_seq_cap = value[fbp_pkg::SEQCAP_W-1:0];
            default:                   cfg_cmp_cap = value[fbp_pkg::CMPCAP_W-1:0];
        endcase
        apb_read(idx, readback);
        check_field("register readback", value & mask, readback);
    endtask

    function automatic logic [fbp_pkg::SIZE_W-1:0] draw_size(
        input logic [fbp_pkg::SEQCAP_W-1:0] cap);
        int unsigned top;
        top = cap / 4;
        if (top > 16'hFFFF)
            top = 16'hFFFF;
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return fbp_pkg::SIZE_W'($urandom);
            default: return fbp_pkg::SIZE_W'($urandom_range(0, top));
        endcase
    endfunction

    task automatic test_reset_values();
        logic [fbp_pkg::PDATA_W-1:0] value;
        apb_read(fbp_pkg::REG_BUCKET_COUNT, value);
        check_field("bucket_count reset", fbp_pkg::BUCKET_COUNT_RST, value);
        apb_read(fbp_pkg::REG_SEQ_CAP, value);
        check_field("sequence_capacity reset", fbp_pkg::SEQ_CAP_RST, value);
        apb_read(fbp_pkg::REG_CMP_CAP, value);
        check_field("comparison_capacity reset", fbp_pkg::CMP_CAP_RST, value);
    endtask

    task automatic test_field_extremes();
        send_pair(16'h0000, 16'h0000);
        send_pair(16'hFFFF, 16'h0000);
        // Fills the bucket to exactly its capacity.
        send_pair(16'h0001, 16'h0000);
        send_pair(16'h0000, 16'hFFFF);
        send_pair(16'hFFFF, 16'hFFFF);
        send_pair(16'h5555, 16'hAAAA);
        send_pair(16'hAAAA, 16'h5555);
        wait_idle();
    endtask

    task automatic test_pair_limit();
        set_reg(fbp_pkg::REG_CMP_CAP, 6);
        repeat (4) send_pair(16'd3, 16'd4);
        wait_idle();
        // Too few comparisons for even one pair.
        set_reg(fbp_pkg::REG_CMP_CAP, 1);
        send_pair(16'd0, 16'd0);
        wait_idle();
        set_reg(fbp_pkg::REG_CMP_CAP, 0);
        send_pair(16'd1, 16'd1);
        wait_idle();
    endtask

    task automatic test_bucket_count_edges();
        set_reg(fbp_pkg::REG_CMP_CAP, 2);
        set_reg(fbp_pkg::REG_BUCKET_COUNT, 0);
        repeat (2) send_pair(16'd7, 16'd9);
        wait_idle();
        set_reg(fbp_pkg::REG_BUCKET_COUNT, 4);
        repeat (4) send_pair(16'd2, 16'd1);
        wait_idle();
        // Still above the open bucket, so the next advance stays in the same batch.
        set_reg(fbp_pkg::REG_BUCKET_COUNT, 2);
        send_pair(16'd5, 16'd5);
        wait_idle();
        set_reg(fbp_pkg::REG_BUCKET_COUNT, 13'h1FFF);
        repeat (2) send_pair(16'd1, 16'd3);
        wait_idle();
    endtask

    task automatic test_capacity_lowered();
        set_reg(fbp_pkg::REG_CMP_CAP, 16'hFFFF);
        set_reg(fbp_pkg::REG_SEQ_CAP, 65536);
        repeat (2) send_pair(16'd1000, 16'd1000);
        wait_idle();
        set_reg(fbp_pkg::REG_SEQ_CAP, 100);
        send_pair(16'd10, 16'd10);
        send_pair(16'd60, 16'd60);
        wait_idle();
        set_reg(fbp_pkg::REG_SEQ_CAP, 0);
        send_pair(16'd0, 16'd0);
        send_pair(16'd1, 16'd0);
        wait_idle();
        set_reg(fbp_pkg::REG_SEQ_CAP, 20'hF_FFFF);
        send_pair(16'hFFFF, 16'hFFFF);
        wait_idle();
    endtask

    // One pair per bucket: walks the bucket index around into a new batch,
    // then steps the batch index with a single bucket per batch.
    task automatic test_index_wrap();
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
        set_reg(fbp_pkg::REG_CMP_CAP, 2);
        set_reg(fbp_pkg::REG_SEQ_CAP, 20'hF_FFFF);
        set_reg(fbp_pkg::REG_BUCKET_COUNT, 200);
        repeat (201) send_pair(fbp_pkg::SIZE_W'($urandom_range(0, 255)),
                               fbp_pkg::SIZE_W'($urandom));
        wait_idle();
        set_reg(fbp_pkg::REG_BUCKET_COUNT, 1);
        repeat (100) send_pair(fbp_pkg::SIZE_W'($urandom),
                               fbp_pkg::SIZE_W'($urandom_range(0, 255)));
        wait_idle();
        tx_idle_en = 1'b1;
        rx_idle_en <= 1'b1;
    endtask

    task automatic test_backpressure();
        set_reg(fbp_pkg::REG_BUCKET_COUNT, 3);
        set_reg(fbp_pkg::REG_SEQ_CAP, 65536);
        set_reg(fbp_pkg::REG_CMP_CAP, 12);
        tx_idle_en = 1'b0;
        hold_reqs <= hold_reqs + 1;
        repeat (24) send_pair(draw_size(cfg_seq_cap), draw_size(cfg_seq_cap));
        wait_idle();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       set_reg(fbp_pkg::REG_BUCKET_COUNT, 0);
                1:       set_reg(fbp_pkg::REG_BUCKET_COUNT, 1);
                2:       set_reg(fbp_pkg::REG_BUCKET_COUNT, $urandom_range(2, 8));
                3:       set_reg(fbp_pkg::REG_BUCKET_COUNT, 4096);
                4:       set_reg(fbp_pkg::REG_BUCKET_COUNT, $urandom_range(4097, 8191));
                default: set_reg(fbp_pkg::REG_BUCKET_COUNT, $urandom_range(1, 4096));
            endcase
            case ($urandom_range(0, 4))
                0:       set_reg(fbp_pkg::REG_SEQ_CAP, $urandom_range(0, 16));
                1:       set_reg(fbp_pkg::REG_SEQ_CAP, $urandom_range(1, 131070));
                2:       set_reg(fbp_pkg::REG_SEQ_CAP, 65536);
                3:       set_reg(fbp_pkg::REG_SEQ_CAP, 20'hF_FFFF);
                default: set_reg(fbp_pkg::REG_SEQ_CAP, $urandom_range(0, 20'hF_FFFF));
            endcase
            case ($urandom_range(0, 3))
                0:       set_reg(fbp_pkg::REG_CMP_CAP, $urandom_range(0, 3));
                1:       set_reg(fbp_pkg::REG_CMP_CAP, $urandom_range(4, 40));
                2:       set_reg(fbp_pkg::REG_CMP_CAP, 16'hFFFF);
                default: set_reg(fbp_pkg::REG_CMP_CAP, $urandom_range(0, 16'hFFFF));
            endcase
            // One phase runs at full rate on both sides.
            tx_idle_en = (phase != 2);
            rx_idle_en <= (phase != 2);
            repeat (160) send_pair(draw_size(cfg_seq_cap), draw_size(cfg_seq_cap));
            wait_idle();
        end
        tx_idle_en = 1'b1;
        rx_idle_en <= 1'b1;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_field_extremes();
        test_pair_limit();
        test_bucket_count_edges();
        test_capacity_lowered();
        test_backpressure();
        test_index_wrap();
        test_random_traffic();
        while (placement_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("fill_first_bucket_packer_tb: done, clean");
        else
            $display("fill_first_bucket_packer_tb: done, errors");
        $finish;
    end

endmodule
